@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes used by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [15:0] TIME_MAX = 16'hFFFF;

   typedef struct packed {
      logic        func;
      logic [7:0]  proc_id;
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] burst;
   } req_type;

   typedef struct packed {
      logic [15:0] tick_time;
      logic [7:0]  run_id;
      logic        idle;
      logic        finished;
      logic [15:0] turnaround;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] remaining;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

@@ src/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Process table in RAM, scanned slot by slot on every tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a load beat (func = load) or a tick beat (func = tick).
//   A load beat appends an entry to the table and gives no result;
//   it is dropped silently once SLOTS entries are stored.
//   A tick beat reads every loaded slot from the table RAM, one per cycle,
//   keeping the best candidate in registers, then writes the chosen entry
//   back with one unit less work and posts one beat on the rsp channel.
//   A tick passes through the scan, update and done states before the rsp
//   register loads, the scan through the single RAM read port setting its
//   length, which grows with the entry count.
//   The next req beat is accepted the cycle after the rsp register loads.
//   req_stall is high while a tick is in progress. The finished result waits
//   in the rsp register while rsp_stall is high; the next beat may be accepted
//   then, and a following tick holds at its end until the register frees.
//   Reset (synchronous) empties the table and sets time to zero; no clearing
//   pass is needed since only loaded slots are ever read.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pps_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENTRY_W = $bits(pps_pkg::entry_type);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   pps_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      time_ff, time_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in;

   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_slot_ff, best_slot_in;
   pps_pkg::entry_type  best_ff, best_in;

   logic                rsp_valid_ff, rsp_valid_in;
   pps_pkg::rsp_type    rsp_ff, rsp_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   pps_pkg::entry_type wr_entry;
   pps_pkg::entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_bits;

   logic        req_fire;
   logic        out_free;
   logic        cand;
   logic        take;
   logic [15:0] done_time;

   pps_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(issue_ff[IDX_W-1:0]),
      .rd_data(rd_bits)
   );

   assign rd_entry = pps_pkg::entry_type'(rd_bits);

   assign req_stall = (state_ff != pps_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // candidate test and tie order: priority, then arrival, then lower slot
   assign cand = (rd_entry.arrival <= time_ff) && (rd_entry.remaining != 16'd0);
   assign take = cand && (!found_ff || (rd_entry.prio < best_ff.prio) ||
                 ((rd_entry.prio == best_ff.prio) &&
                  (rd_entry.arrival < best_ff.arrival)));

   assign done_time = (time_ff == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                     : time_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff     <= issue_in;
      rd_slot_ff   <= rd_slot_in;
      best_slot_ff <= best_slot_in;
      best_ff      <= best_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_slot_in   = rd_slot_ff;
      found_in     = found_ff;
      best_slot_in = best_slot_ff;
      best_in      = best_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      wr_en              = 1'b0;
      wr_addr            = count_ff[IDX_W-1:0];
      wr_entry.id        = req_data.proc_id;
      wr_entry.prio      = req_data.prio;
      wr_entry.arrival   = req_data.arrival;
      wr_entry.remaining = req_data.burst;

      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.func == pps_pkg::FUNC_LOAD) begin
                  if (count_ff < SLOTS_CNT) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  issue_in = '0;
                  found_in = 1'b0;
                  state_in = pps_pkg::ST_SCAN;
               end
            end
         end
         pps_pkg::ST_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_slot_in  = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = pps_pkg::ST_UPDATE;
            end
            if (rd_valid_ff && take) begin
               found_in     = 1'b1;
               best_slot_in = rd_slot_ff;
               best_in      = rd_entry;
            end
         end
         pps_pkg::ST_UPDATE: begin
            if (found_ff) begin
               wr_en              = 1'b1;
               wr_addr            = best_slot_ff;
               wr_entry           = best_ff;
               wr_entry.remaining = best_ff.remaining - 16'd1;
            end
            state_in = pps_pkg::ST_DONE;
         end
         pps_pkg::ST_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_in.tick_time  = time_ff;
               rsp_in.run_id     = 8'd0;
               rsp_in.idle       = 1'b1;
               rsp_in.finished   = 1'b0;
               rsp_in.turnaround = 16'd0;
               if (found_ff) begin
                  rsp_in.run_id = best_ff.id;
                  rsp_in.idle   = 1'b0;
                  if (best_ff.remaining == 16'd1) begin
                     rsp_in.finished   = 1'b1;
                     rsp_in.turnaround = done_time - best_ff.arrival;
                  end
               end
               rsp_valid_in = 1'b1;
               if (time_ff != pps_pkg::TIME_MAX) begin
                  time_in = time_ff + 16'd1;
               end
               state_in = pps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
